/* src/mono_framebuffer_pixel_packer_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the mono frame buffer pixel packer
// Shared property wrappers, clocked on the rising edge, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MONO_FRAMEBUFFER_PIXEL_PACKER_MACROS_SVH
`define MONO_FRAMEBUFFER_PIXEL_PACKER_MACROS_SVH

// same-cycle implication
`define MFPP_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MFPP_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/mfpp_pkg.sv */
// ----------------------------------------------------------------------------
// mfpp_pkg
// Shared types and constants of the mono frame buffer pixel packer.
// ----------------------------------------------------------------------------
package mfpp_pkg;

  localparam int FRAME_BYTES_DEF = 16384;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [15:0] THRESHOLD = 16'h7fff;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_FILL  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [2:0] pos;
    logic       pix;
    logic       status;
    logic [7:0] fill;
  } item_ctl_t;

endpackage

/* src/mono_framebuffer_pixel_packer.sv */
// Path: a pixel write or byte read passes the front-end stage register, the
// command queue, the store read and the result register. The back end's
// read-modify-write on the single-port store holds off the next command.
// Fill: one store byte written per cycle, holding on the last while stalled.
// Reset: control cleared, configuration set to defaults (landscape, 400 x 300);
// the frame store is not cleared, no clearing pass.
// ----------------------------------------------------------------------------
// mono_framebuffer_pixel_packer
// Top level: configuration registers, front end, command queue, back end.
// ----------------------------------------------------------------------------
module mono_framebuffer_pixel_packer #(
  parameter int FRAME_BYTES = mfpp_pkg::FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [8:0]  in_pixel_x,
  input  logic [8:0]  in_pixel_y,
  input  logic [15:0] in_pixel_value,
  input  logic [13:0] in_byte_address,
  input  logic [7:0]  in_fill_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_status
);
  import mfpp_pkg::*;

  localparam int IDX_W = $clog2(FRAME_BYTES);

  localparam logic [1:0] REG_LANDSCAPE = 2'd0;
  localparam logic [1:0] REG_WIDTH     = 2'd1;
  localparam logic [1:0] REG_HEIGHT    = 2'd2;

  localparam logic [9:0] WIDTH_RST  = 10'd400;
  localparam logic [9:0] HEIGHT_RST = 10'd300;

  logic       landscape_r, landscape_nxt;
  logic [9:0] width_r, width_nxt;
  logic [9:0] height_r, height_nxt;
  logic       cfg_wr;

  logic             q_push, q_pop, q_full, q_empty;
  item_ctl_t        push_ctl, head_ctl;
  logic [IDX_W-1:0] push_idx, head_idx;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    landscape_nxt = landscape_r;
    width_nxt     = width_r;
    height_nxt    = height_r;
    if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_LANDSCAPE: landscape_nxt = pwdata[0];
        REG_WIDTH:     width_nxt     = pwdata[9:0];
        REG_HEIGHT:    height_nxt    = pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LANDSCAPE: prdata = {31'd0, landscape_r};
      REG_WIDTH:     prdata = {22'd0, width_r};
      REG_HEIGHT:    prdata = {22'd0, height_r};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      landscape_r <= 1'b1;
      width_r     <= WIDTH_RST;
      height_r    <= HEIGHT_RST;
    end else begin
      landscape_r <= landscape_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
    end
  end

  mfpp_front #(
    .FRAME_BYTES (FRAME_BYTES),
    .IDX_W       (IDX_W)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .landscape_mode  (landscape_r),
    .frame_width     (width_r),
    .frame_height    (height_r),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .in_pixel_value  (in_pixel_value),
    .in_byte_address (in_byte_address),
    .in_fill_byte    (in_fill_byte),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_ctl           (push_ctl),
    .q_idx           (push_idx)
  );

  mfpp_queue #(
    .IDX_W (IDX_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_ctl (push_ctl),
    .push_idx (push_idx),
    .pop      (q_pop),
    .head_ctl (head_ctl),
    .head_idx (head_idx),
    .full     (q_full),
    .empty    (q_empty)
  );

  mfpp_back #(
    .FRAME_BYTES (FRAME_BYTES),
    .IDX_W       (IDX_W)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_ctl         (head_ctl),
    .q_idx         (head_idx),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data),
    .out_status    (out_status)
  );

endmodule

/* src/mfpp_front.sv */
// ----------------------------------------------------------------------------
// mfpp_front
// Accepts commands, maps pixel coordinates to a byte index and bit position,
// range checks, and pushes classified work into the queue.
// ----------------------------------------------------------------------------
module mfpp_front #(
  parameter int FRAME_BYTES = mfpp_pkg::FRAME_BYTES_DEF,
  parameter int IDX_W       = $clog2(FRAME_BYTES)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  landscape_mode,
  input  logic [9:0]            frame_width,
  input  logic [9:0]            frame_height,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_command,
  input  logic [8:0]            in_pixel_x,
  input  logic [8:0]            in_pixel_y,
  input  logic [15:0]           in_pixel_value,
  input  logic [13:0]           in_byte_address,
  input  logic [7:0]            in_fill_byte,
  input  logic                  q_full,
  output logic                  q_push,
  output mfpp_pkg::item_ctl_t   q_ctl,
  output logic [IDX_W-1:0]      q_idx
);
  import mfpp_pkg::*;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_FILL  = 2'd2;

  logic             vld_a_r, vld_a_nxt;
  item_ctl_t        ctl_a_r, ctl_a_nxt;
  logic [15:0]      prod_a_r;
  logic [7:0]       addend_a_r, addend_nxt;
  logic [IDX_W-1:0] rdidx_a_r;

  logic             accept;
  logic             in_range;
  logic             addr_ok;
  logic [9:0]       iy;
  logic [7:0]       mul_a, mul_b;
  logic [31:0]      addr_ext;
  logic [16:0]      idx_sum;

  assign accept   = in_valid && !in_stall;
  assign in_stall = vld_a_r && q_full;
  assign q_push   = vld_a_r && !q_full;

  assign in_range = ({1'b0, in_pixel_x} < frame_width) &&
                    ({1'b0, in_pixel_y} < frame_height);
  assign iy       = frame_height - 10'd1 - {1'b0, in_pixel_y};
  assign addr_ext = 32'(in_byte_address);
  assign addr_ok  = addr_ext < 32'(FRAME_BYTES);

  always_comb begin
    ctl_a_nxt        = '0;
    ctl_a_nxt.fill   = in_fill_byte;
    ctl_a_nxt.pix    = (in_pixel_value >= THRESHOLD);
    if (landscape_mode) begin
      mul_a         = in_pixel_x[8:1];
      mul_b         = frame_height[9:2];
      addend_nxt    = iy[9:2];
      ctl_a_nxt.pos = {iy[1:0], in_pixel_x[0]};
    end else begin
      mul_a         = in_pixel_y[8:1];
      mul_b         = frame_width[9:2];
      addend_nxt    = {1'b0, in_pixel_x[8:2]};
      ctl_a_nxt.pos = {in_pixel_x[1:0], in_pixel_y[0]};
    end
    unique case (in_command)
      CMD_WRITE: begin
        ctl_a_nxt.kind   = in_range ? KIND_WRITE : KIND_NONE;
        ctl_a_nxt.status = !in_range;
      end
      CMD_READ: begin
        ctl_a_nxt.kind   = addr_ok ? KIND_READ : KIND_NONE;
        ctl_a_nxt.status = !addr_ok;
      end
      CMD_FILL: begin
        ctl_a_nxt.kind   = KIND_FILL;
        ctl_a_nxt.status = 1'b0;
      end
      default: begin
        ctl_a_nxt.kind   = KIND_NONE;
        ctl_a_nxt.status = 1'b1;
      end
    endcase
  end

  always_comb begin
    vld_a_nxt = vld_a_r;
    if (accept) begin
      vld_a_nxt = 1'b1;
    end else if (q_push) begin
      vld_a_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
    end else begin
      vld_a_r <= vld_a_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctl_a_r    <= ctl_a_nxt;
      prod_a_r   <= 16'(mul_a) * 16'(mul_b);
      addend_a_r <= addend_nxt;
      rdidx_a_r  <= addr_ext[IDX_W-1:0];
    end
  end

  // second half: finish the index and catch writes past the store
  assign idx_sum = {1'b0, prod_a_r} + 17'(addend_a_r);

  always_comb begin
    q_ctl = ctl_a_r;
    q_idx = rdidx_a_r;
    if (ctl_a_r.kind == KIND_WRITE) begin
      q_idx = idx_sum[IDX_W-1:0];
      if (32'(idx_sum) >= 32'(FRAME_BYTES)) begin
        q_ctl.kind   = KIND_NONE;
        q_ctl.status = 1'b1;
      end
    end
  end

endmodule

/* src/mfpp_queue.sv */
// ----------------------------------------------------------------------------
// mfpp_queue
// Short FIFO of classified commands between front and back.
// ----------------------------------------------------------------------------
module mfpp_queue #(
  parameter int IDX_W = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mfpp_pkg::item_ctl_t push_ctl,
  input  logic [IDX_W-1:0]    push_idx,
  input  logic                pop,
  output mfpp_pkg::item_ctl_t head_ctl,
  output logic [IDX_W-1:0]    head_idx,
  output logic                full,
  output logic                empty
);
  import mfpp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  item_ctl_t        ctl_mem [QUEUE_DEPTH];
  logic [IDX_W-1:0] idx_mem [QUEUE_DEPTH];

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign head_ctl = ctl_mem[head_r];
  assign head_idx = idx_mem[head_r];

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (push) begin
      tail_nxt = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);
    end
    if (pop) begin
      head_nxt = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ctl_mem[tail_r] <= push_ctl;
      idx_mem[tail_r] <= push_idx;
    end
  end

endmodule

/* src/mfpp_back.sv */
// ----------------------------------------------------------------------------
// mfpp_back
// Executes queued commands against the frame store: pixel read-modify-write,
// byte read, whole-store fill, rejected-command status; owns the result register.
// ----------------------------------------------------------------------------
`include "mono_framebuffer_pixel_packer_macros.svh"

module mfpp_back #(
  parameter int FRAME_BYTES = mfpp_pkg::FRAME_BYTES_DEF,
  parameter int IDX_W       = $clog2(FRAME_BYTES)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  mfpp_pkg::item_ctl_t q_ctl,
  input  logic [IDX_W-1:0]    q_idx,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_read_data,
  output logic                out_status
);
  import mfpp_pkg::*;

  localparam logic [IDX_W-1:0] FILL_LAST = IDX_W'(FRAME_BYTES - 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_MODIFY = 4'b0010,
    S_READ   = 4'b0100,
    S_FILL   = 4'b1000
  } state_t;

  logic [7:0] frame_mem [FRAME_BYTES];

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [2:0]       pos_r, pos_nxt;
  logic             pix_r, pix_nxt;
  logic [7:0]       fill_byte_r, fill_byte_nxt;
  logic [IDX_W-1:0] fill_cnt_r, fill_cnt_nxt;
  logic [7:0]       rdata_r;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_read_data_r;
  logic             out_status_r;

  logic             out_free;
  logic             mem_re, mem_we;
  logic [IDX_W-1:0] mem_wa;
  logic [7:0]       mem_wd;
  logic [7:0]       bit_mask;
  logic [7:0]       modified;
  logic             res_load;
  logic [7:0]       res_data;
  logic             res_status;

  assign out_free = !out_valid_r || !out_stall;
  assign bit_mask = 8'b1 << (~pos_r);
  assign modified = pix_r ? (rdata_r | bit_mask) : (rdata_r & ~bit_mask);

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    pix_nxt       = pix_r;
    fill_byte_nxt = fill_byte_r;
    fill_cnt_nxt  = fill_cnt_r;
    q_pop         = 1'b0;
    mem_re        = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = idx_r;
    mem_wd        = modified;
    res_load      = 1'b0;
    res_data      = '0;
    res_status    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          unique case (q_ctl.kind)
            KIND_WRITE: begin
              q_pop     = 1'b1;
              mem_re    = 1'b1;
              idx_nxt   = q_idx;
              pos_nxt   = q_ctl.pos;
              pix_nxt   = q_ctl.pix;
              state_nxt = S_MODIFY;
            end
            KIND_READ: begin
              q_pop     = 1'b1;
              mem_re    = 1'b1;
              state_nxt = S_READ;
            end
            KIND_FILL: begin
              q_pop         = 1'b1;
              fill_byte_nxt = q_ctl.fill;
              fill_cnt_nxt  = '0;
              state_nxt     = S_FILL;
            end
            default: begin
              if (out_free) begin
                q_pop      = 1'b1;
                res_load   = 1'b1;
                res_status = q_ctl.status;
              end
            end
          endcase
        end
      end
      S_MODIFY: begin
        if (out_free) begin
          mem_we    = 1'b1;
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          res_load  = 1'b1;
          res_data  = rdata_r;
          state_nxt = S_IDLE;
        end
      end
      S_FILL: begin
        mem_we = 1'b1;
        mem_wa = fill_cnt_r;
        mem_wd = fill_byte_r;
        if (fill_cnt_r == FILL_LAST) begin
          if (out_free) begin
            res_load     = 1'b1;
            fill_cnt_nxt = '0;
            state_nxt    = S_IDLE;
          end
        end else begin
          fill_cnt_nxt = fill_cnt_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    pos_r       <= pos_nxt;
    pix_r       <= pix_nxt;
    fill_byte_r <= fill_byte_nxt;
    if (res_load) begin
      out_read_data_r <= res_data;
      out_status_r    <= res_status;
    end
  end

  // frame store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= frame_mem[q_idx];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_status    = out_status_r;

  `MFPP_ASSERT_IMP(a_idle_cnt_zero, clk, rst_n, state_r == S_IDLE, fill_cnt_r == '0, "fill counter not zero in idle")
  `MFPP_ASSERT_IMP(a_fill_cnt_range, clk, rst_n, state_r == S_FILL, 32'(fill_cnt_r) < 32'(FRAME_BYTES), "fill counter past store")
  `MFPP_ASSERT_NXT(a_single_op_done, clk, rst_n, (state_r == S_MODIFY || state_r == S_READ) && out_free, state_r == S_IDLE, "read or write did not finish")
  `MFPP_ASSERT_IMP(a_no_rw_clash, clk, rst_n, mem_we, !mem_re, "store read and write in one cycle")

endmodule
